// ===== design/rlc_am_seg_pkg.sv =====
// Shared types, codes and sizes of the RLC AM segmentation unit.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package rlc_am_seg_pkg;

  // Size of the segment table (one entry per sequence number).
  localparam int unsigned MaxSegs = 256;
  localparam int unsigned SnW     = 8;
  localparam int unsigned LenW    = 16;
  // Sequence counter has one spare bit so that it can reach the table size.
  localparam int unsigned SeqCntW = SnW + 1;
  // Table entry: start in the low field, length above it, end-of-SDU on top.
  localparam int unsigned EntryW  = 2 * LenW + 1;
  localparam int unsigned TabAddrW = $clog2(MaxSegs);

  typedef enum logic [1:0] {
    CmdNewSdu = 2'b00,
    CmdGrant  = 2'b01,
    CmdMark   = 2'b10,
    CmdRetx   = 2'b11
  } cmd_e;

  // Result status codes.
  localparam logic [1:0] StatusSeg = 2'b00;
  localparam logic [1:0] StatusOk  = 2'b01;
  localparam logic [1:0] StatusErr = 2'b10;

  // Segmentation information codes.
  localparam logic [1:0] SiFull   = 2'b00;
  localparam logic [1:0] SiFirst  = 2'b01;
  localparam logic [1:0] SiLast   = 2'b10;
  localparam logic [1:0] SiMiddle = 2'b11;

  typedef struct packed {
    logic [1:0]      status;
    logic [SnW-1:0]  seq_num;
    logic [1:0]      seg_info;
    logic            offset_present;
    logic [LenW-1:0] seg_offset;
    logic [LenW-1:0] seg_bytes;
    logic            more_data;
  } result_t;

  // SI from whether the piece holds the first and/or the last SDU byte.
  function automatic logic [1:0] pick_si(input logic has_first, input logic has_last);
    logic [1:0] si;
    if (has_first && has_last) begin
      si = SiFull;
    end else if (has_first) begin
      si = SiFirst;
    end else if (has_last) begin
      si = SiLast;
    end else begin
      si = SiMiddle;
    end
    return si;
  endfunction

endpackage

`default_nettype wire

// ===== design/rlc_am_segmentation_unit.sv =====
// RLC AM segmentation and resegmentation unit: segment descriptors per grant.
// Depends on rlc_am_seg_pkg for sizes, codes and the result type.
//
//   channel  direction  handshake                 payload
//   in       request in in_valid_i / in_ready_o   command, sdu_length, grant_size, target_sn
//   out      result out out_valid_o / out_ready_i status, seq_num, seg_info, offset_present,
//                                                 seg_offset, seg_bytes, more_data
//
// For a new SDU, a transmit grant and a mark, the result is registered at the
// edge that takes the request. A retransmit grant first reads the stored segment
// into the registered table read data; its cut is made from that and registered.
// One request is in flight at a time; a waiting result does not block the next
// request as long as it is taken in the same cycle. Reset clears all control
// state; a sequence number counts as recorded exactly when it lies below the
// sequence counter, so no clearing pass over the table is needed.
`default_nettype none

module rlc_am_segmentation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] sdu_length_i,
  input  wire logic [15:0] grant_size_i,
  input  wire logic [7:0]  target_sn_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       seq_num_o,
  output logic [1:0]       seg_info_o,
  output logic             offset_present_o,
  output logic [15:0]      seg_offset_o,
  output logic [15:0]      seg_bytes_o,
  output logic             more_data_o
);

  localparam int unsigned SnW     = rlc_am_seg_pkg::SnW;
  localparam int unsigned LenW    = rlc_am_seg_pkg::LenW;
  localparam int unsigned SeqCntW = rlc_am_seg_pkg::SeqCntW;
  localparam int unsigned EntryW  = rlc_am_seg_pkg::EntryW;
  localparam int unsigned MaxSegs = rlc_am_seg_pkg::MaxSegs;

  typedef enum logic {
    S_IDLE,
    S_RETX
  } state_e;

  state_e                  state_q, state_d;
  logic [LenW-1:0]         sdu_len_q, sdu_len_d;
  logic [LenW-1:0]         tx_offset_q, tx_offset_d;
  logic [SeqCntW-1:0]      next_seq_q, next_seq_d;
  logic [SnW-1:0]          retx_seq_q, retx_seq_d;
  logic [LenW-1:0]         retx_offset_q, retx_offset_d;
  logic                    retx_armed_q, retx_armed_d;
  logic [LenW-1:0]         grant_q, grant_d;
  rlc_am_seg_pkg::result_t out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    accept;
  rlc_am_seg_pkg::cmd_e    cmd;

  // Segment table memory with a registered read.
  logic [EntryW-1:0]       mem [MaxSegs];
  logic [EntryW-1:0]       rdata_q;
  logic                    mem_we;
  logic                    mem_re;
  logic [EntryW-1:0]       mem_wdata;

  // New-transmission datapath.
  logic                    tx_err;
  logic [LenW-1:0]         tx_remaining;
  logic [LenW-1:0]         tx_bytes;
  logic [LenW:0]           tx_end;
  logic                    tx_ends;

  // Retransmission datapath on the table read data.
  logic [LenW-1:0]         r_start;
  logic [LenW-1:0]         r_len;
  logic                    r_end;
  logic                    r_err;
  logic [LenW-1:0]         r_remaining;
  logic [LenW-1:0]         r_bytes;
  logic [LenW-1:0]         r_abs;
  logic [LenW:0]           r_sum;
  logic                    r_last;

  logic                    mark_err;
  logic                    retx_pre_err;

  assign cmd        = rlc_am_seg_pkg::cmd_e'(command_i);
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Cut of a fresh segment from the untransmitted part of the SDU.
  assign tx_err = (grant_size_i == '0) || (tx_offset_q >= sdu_len_q)
               || (32'(next_seq_q) >= MaxSegs) || next_seq_q[SeqCntW-1];
  assign tx_remaining = sdu_len_q - tx_offset_q;
  assign tx_bytes     = (grant_size_i < tx_remaining) ? grant_size_i : tx_remaining;
  assign tx_end       = {1'b0, tx_offset_q} + {1'b0, tx_bytes};
  assign tx_ends      = (tx_end == {1'b0, sdu_len_q});

  // Cut of the next piece of the armed segment.
  assign r_start     = rdata_q[LenW-1:0];
  assign r_len       = rdata_q[2*LenW-1:LenW];
  assign r_end       = rdata_q[EntryW-1];
  assign r_err       = (retx_offset_q >= r_len);
  assign r_remaining = r_len - retx_offset_q;
  assign r_bytes     = (grant_q < r_remaining) ? grant_q : r_remaining;
  assign r_abs       = r_start + retx_offset_q;
  assign r_sum       = {1'b0, retx_offset_q} + {1'b0, r_bytes};
  assign r_last      = r_end && (r_sum == {1'b0, r_len});

  // Sequence numbers are recorded in order, so one is known exactly when it
  // lies below the sequence counter.
  assign mark_err     = (32'(target_sn_i) >= MaxSegs) || ({1'b0, target_sn_i} >= next_seq_q);
  assign retx_pre_err = (grant_size_i == '0) || !retx_armed_q
                     || (32'(retx_seq_q) >= MaxSegs) || ({1'b0, retx_seq_q} >= next_seq_q);

  // Table accesses: written by a good transmit grant, read by a retransmit grant.
  assign mem_we    = accept && (cmd == rlc_am_seg_pkg::CmdGrant) && !tx_err;
  assign mem_re    = accept && (cmd == rlc_am_seg_pkg::CmdRetx);
  assign mem_wdata = {tx_ends, tx_bytes, tx_offset_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[next_seq_q[SnW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[retx_seq_q];
    end
  end

  // Next-state and result logic.
  always_comb begin
    state_d       = state_q;
    sdu_len_d     = sdu_len_q;
    tx_offset_d   = tx_offset_q;
    next_seq_d    = next_seq_q;
    retx_seq_d    = retx_seq_q;
    retx_offset_d = retx_offset_q;
    retx_armed_d  = retx_armed_q;
    grant_d       = grant_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d           = '0;
          out_d.more_data = (tx_offset_q < sdu_len_q);
          unique case (cmd)
            rlc_am_seg_pkg::CmdNewSdu: begin
              sdu_len_d       = sdu_length_i;
              tx_offset_d     = '0;
              next_seq_d      = '0;
              retx_offset_d   = '0;
              retx_armed_d    = 1'b0;
              out_d.status    = rlc_am_seg_pkg::StatusOk;
              out_d.more_data = (sdu_length_i != '0);
              out_valid_d     = 1'b1;
            end
            rlc_am_seg_pkg::CmdGrant: begin
              if (tx_err) begin
                out_d.status = rlc_am_seg_pkg::StatusErr;
              end else begin
                next_seq_d           = next_seq_q + SeqCntW'(1);
                tx_offset_d          = tx_end[LenW-1:0];
                out_d.status         = rlc_am_seg_pkg::StatusSeg;
                out_d.seq_num        = next_seq_q[SnW-1:0];
                out_d.seg_info       = rlc_am_seg_pkg::pick_si(tx_offset_q == '0, tx_ends);
                out_d.offset_present = (tx_offset_q != '0);
                out_d.seg_offset     = tx_offset_q;
                out_d.seg_bytes      = tx_bytes;
                out_d.more_data      = (tx_end[LenW-1:0] < sdu_len_q);
              end
              out_valid_d = 1'b1;
            end
            rlc_am_seg_pkg::CmdMark: begin
              if (mark_err) begin
                out_d.status = rlc_am_seg_pkg::StatusErr;
              end else begin
                retx_seq_d    = target_sn_i;
                retx_offset_d = '0;
                retx_armed_d  = 1'b1;
                out_d.status  = rlc_am_seg_pkg::StatusOk;
              end
              out_valid_d = 1'b1;
            end
            rlc_am_seg_pkg::CmdRetx: begin
              if (retx_pre_err) begin
                out_d.status = rlc_am_seg_pkg::StatusErr;
                out_valid_d  = 1'b1;
              end else begin
                grant_d = grant_size_i;
                state_d = S_RETX;
              end
            end
            default: begin
              out_d.status = rlc_am_seg_pkg::StatusErr;
              out_valid_d  = 1'b1;
            end
          endcase
        end
      end
      S_RETX: begin
        // The output register drained when the request was taken.
        out_d           = '0;
        out_d.more_data = (tx_offset_q < sdu_len_q);
        if (r_err) begin
          out_d.status = rlc_am_seg_pkg::StatusErr;
        end else begin
          retx_offset_d        = r_sum[LenW-1:0];
          out_d.status         = rlc_am_seg_pkg::StatusSeg;
          out_d.seq_num        = retx_seq_q;
          out_d.seg_info       = rlc_am_seg_pkg::pick_si(r_abs == '0, r_last);
          out_d.offset_present = (r_abs != '0);
          out_d.seg_offset     = r_abs;
          out_d.seg_bytes      = r_bytes;
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, control registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sdu_len_q     <= '0;
      tx_offset_q   <= '0;
      next_seq_q    <= '0;
      retx_seq_q    <= '0;
      retx_offset_q <= '0;
      retx_armed_q  <= 1'b0;
      grant_q       <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      sdu_len_q     <= sdu_len_d;
      tx_offset_q   <= tx_offset_d;
      next_seq_q    <= next_seq_d;
      retx_seq_q    <= retx_seq_d;
      retx_offset_q <= retx_offset_d;
      retx_armed_q  <= retx_armed_d;
      grant_q       <= grant_d;
      out_q         <= out_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign seq_num_o        = out_q.seq_num;
  assign seg_info_o       = out_q.seg_info;
  assign offset_present_o = out_q.offset_present;
  assign seg_offset_o     = out_q.seg_offset;
  assign seg_bytes_o      = out_q.seg_bytes;
  assign more_data_o      = out_q.more_data;

endmodule

`default_nettype wire

// ===== design/rlc_am_seg_checker.sv =====
// Port-level checks for the RLC AM segmentation unit, with its bind.
// Depends on rlc_am_seg_pkg for the command and status codes.
`default_nettype none

module rlc_am_seg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  command_i,
  input wire logic [15:0] sdu_length_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  seq_num_o,
  input wire logic [1:0]  seg_info_o,
  input wire logic        offset_present_o,
  input wire logic [15:0] seg_offset_o,
  input wire logic [15:0] seg_bytes_o,
  input wire logic        more_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(seg_bytes_o) && $stable(seg_offset_o))
    else $error("stalled result changed");

  // Results without a segment carry zero descriptor fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rlc_am_seg_pkg::StatusSeg)
      |-> (seq_num_o == '0) && (seg_info_o == '0) && !offset_present_o
          && (seg_offset_o == '0) && (seg_bytes_o == '0))
    else $error("descriptor fields set on a non-segment result");

  // An emitted segment is never empty and flags its offset exactly when nonzero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rlc_am_seg_pkg::StatusSeg)
      |-> (seg_bytes_o != '0) && (offset_present_o == (seg_offset_o != '0)))
    else $error("bad segment length or offset flag");

  // A new-SDU request is answered in the next cycle with its data flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == rlc_am_seg_pkg::CmdNewSdu)
      |=> out_valid_o && (status_o == rlc_am_seg_pkg::StatusOk)
          && (more_data_o == ($past(sdu_length_i) != '0)))
    else $error("new SDU not acknowledged");

endmodule

bind rlc_am_segmentation_unit rlc_am_seg_checker u_rlc_am_seg_checker (.*);

`default_nettype wire

// ===== dv/rlc_am_segmentation_unit_tb.sv =====
// Self-checking testbench for the RLC AM segmentation unit: directed and random requests.
// Depends on rlc_am_seg_pkg and rlc_am_segmentation_unit; it predicts every
// segment descriptor and checks each result against the oldest prediction.
`default_nettype none

module rlc_am_segmentation_unit_tb;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandomOps = 510;
  localparam int unsigned MaxSegs   = rlc_am_seg_pkg::MaxSegs;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [15:0] sdu_length_i;
  logic [15:0] grant_size_i;
  logic [7:0]  target_sn_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  seq_num_o;
  logic [1:0]  seg_info_o;
  logic        offset_present_o;
  logic [15:0] seg_offset_o;
  logic [15:0] seg_bytes_o;
  logic        more_data_o;

  rlc_am_segmentation_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .sdu_length_i     (sdu_length_i),
    .grant_size_i     (grant_size_i),
    .target_sn_i      (target_sn_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .seq_num_o        (seq_num_o),
    .seg_info_o       (seg_info_o),
    .offset_present_o (offset_present_o),
    .seg_offset_o     (seg_offset_o),
    .seg_bytes_o      (seg_bytes_o),
    .more_data_o      (more_data_o)
  );

  // Clock with a period of 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted state of the unit.
  int unsigned sdu_bytes;
  int unsigned sent_bytes;
  int unsigned sn_counter;
  logic [7:0]  resend_sn;
  int unsigned resend_done;
  bit          resend_armed;
  int unsigned rec_start [MaxSegs];
  int unsigned rec_len   [MaxSegs];
  bit          rec_ends  [MaxSegs];
  bit          rec_valid [MaxSegs];

  // Descriptors still owed by the unit, oldest first.
  rlc_am_seg_pkg::result_t pending_results[$];

  int unsigned mismatches;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned rx_hold_left;
  int unsigned rx_gap_left;
  int unsigned idle_cycles;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // SI code from whether a piece carries the first and the last SDU byte.
  function automatic logic [1:0] si_code(input bit holds_first, input bit holds_last);
    if (holds_first && holds_last) return rlc_am_seg_pkg::SiFull;
    if (holds_first) return rlc_am_seg_pkg::SiFirst;
    if (holds_last) return rlc_am_seg_pkg::SiLast;
    return rlc_am_seg_pkg::SiMiddle;
  endfunction

  // Builds a descriptor; more_data reflects the state after the request.
  function automatic rlc_am_seg_pkg::result_t make_result(
      input logic [1:0] status, input int unsigned sn, input logic [1:0] si,
      input int unsigned start, input int unsigned bytes);
    rlc_am_seg_pkg::result_t r;
    r.status         = status;
    r.seq_num        = sn[7:0];
    r.seg_info       = si;
    r.offset_present = (status == rlc_am_seg_pkg::StatusSeg) && (start != 0);
    r.seg_offset     = start[15:0];
    r.seg_bytes      = bytes[15:0];
    r.more_data      = sent_bytes < sdu_bytes;
    return r;
  endfunction

  // Works out the descriptor for one accepted request and updates the state.
  task automatic predict_descriptor(input rlc_am_seg_pkg::cmd_e cmd, input logic [15:0] len,
                                    input logic [15:0] grant, input logic [7:0] sn);
    rlc_am_seg_pkg::result_t r;
    int unsigned avail;
    int unsigned take;
    int unsigned start;
    bit          at_end;
    r = make_result(rlc_am_seg_pkg::StatusErr, 0, rlc_am_seg_pkg::SiFull, 0, 0);
    case (cmd)
      rlc_am_seg_pkg::CmdNewSdu: begin
        sdu_bytes    = 32'(len);
        sent_bytes   = 0;
        sn_counter   = 0;
        resend_done  = 0;
        resend_armed = 1'b0;
        foreach (rec_valid[i]) rec_valid[i] = 1'b0;
        r = make_result(rlc_am_seg_pkg::StatusOk, 0, rlc_am_seg_pkg::SiFull, 0, 0);
      end
      rlc_am_seg_pkg::CmdGrant: begin
        if (grant != 0 && sent_bytes < sdu_bytes && sn_counter < MaxSegs) begin
          avail  = sdu_bytes - sent_bytes;
          take   = (32'(grant) < avail) ? 32'(grant) : avail;
          at_end = (sent_bytes + take == sdu_bytes);
          start  = sent_bytes;
          rec_start[sn_counter] = start;
          rec_len[sn_counter]   = take;
          rec_ends[sn_counter]  = at_end;
          rec_valid[sn_counter] = 1'b1;
          sent_bytes = sent_bytes + take;
          r = make_result(rlc_am_seg_pkg::StatusSeg, sn_counter,
                          si_code(start == 0, at_end), start, take);
          sn_counter++;
        end
      end
      rlc_am_seg_pkg::CmdMark: begin
        if (rec_valid[sn]) begin
          resend_sn    = sn;
          resend_done  = 0;
          resend_armed = 1'b1;
          r = make_result(rlc_am_seg_pkg::StatusOk, 0, rlc_am_seg_pkg::SiFull, 0, 0);
        end
      end
      default: begin
        if (grant != 0 && resend_armed && rec_valid[resend_sn] &&
            resend_done < rec_len[resend_sn]) begin
          avail  = rec_len[resend_sn] - resend_done;
          take   = (32'(grant) < avail) ? 32'(grant) : avail;
          start  = rec_start[resend_sn] + resend_done;
          at_end = rec_ends[resend_sn] && (resend_done + take == rec_len[resend_sn]);
          resend_done = resend_done + take;
          r = make_result(rlc_am_seg_pkg::StatusSeg, 32'(resend_sn),
                          si_code(start == 0, at_end), start, take);
        end
      end
    endcase
    pending_results.push_back(r);
  endtask

  // Offers one request, holds it until taken, then records its prediction.
  task automatic send_request(input rlc_am_seg_pkg::cmd_e cmd, input logic [15:0] len,
                              input logic [15:0] grant, input logic [7:0] sn);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    sdu_length_i <= len;
    grant_size_i <= grant;
    target_sn_i  <= sn;
    do @(posedge clk_i); while (!in_ready_o);
    predict_descriptor(cmd, len, grant, sn);
  endtask

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Grant sizes: mostly within a typical bound, sometimes any value or zero.
  function automatic logic [15:0] rand_grant(input int unsigned typical_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 15) return 16'($urandom_range(0, 65535));
    if (r < 30) return 16'($urandom_range(1, 1024));
    return 16'($urandom_range(1, typical_max));
  endfunction

  // One random request, shaped by the predicted state; unused fields are random.
  task automatic send_random_request();
    int unsigned r;
    logic [15:0] len;
    logic [7:0]  sn;
    r   = $urandom_range(0, 99);
    len = 16'($urandom_range(0, 65535));
    sn  = 8'($urandom_range(0, 255));
    if (r < 6) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = 16'($urandom_range(1, 600));
      else if (r < 75) len = 16'd0;
      else if (r < 80) len = 16'hFFFF;
      send_request(rlc_am_seg_pkg::CmdNewSdu, len, 16'($urandom_range(0, 65535)), sn);
    end else if (r < 50) begin
      send_request(rlc_am_seg_pkg::CmdGrant, len, rand_grant(64), sn);
    end else if (r < 65) begin
      if (sn_counter > 0 && $urandom_range(0, 99) < 80) begin
        sn = 8'($urandom_range(0, sn_counter - 1));
      end
      send_request(rlc_am_seg_pkg::CmdMark, len, 16'($urandom_range(0, 65535)), sn);
    end else if (r < 95) begin
      send_request(rlc_am_seg_pkg::CmdRetx, len, rand_grant(16), sn);
    end else begin
      send_request(rlc_am_seg_pkg::cmd_e'($urandom_range(0, 3)), len,
                   16'($urandom_range(0, 65535)), sn);
    end
  endtask

  // Result side: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else if (rx_gap_left > 0) begin
      out_ready_i <= 1'b0;
      rx_gap_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 99) < 40) rx_gap_left = pick_gap();
    end
  end

  // Compares each result taken with the oldest prediction.
  always @(posedge clk_i) begin
    rlc_am_seg_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (seq_num_o !== want.seq_num) begin
          report_mismatch("seq_num", 32'(seq_num_o), 32'(want.seq_num));
        end
        if (seg_info_o !== want.seg_info) begin
          report_mismatch("seg_info", 32'(seg_info_o), 32'(want.seg_info));
        end
        if (offset_present_o !== want.offset_present) begin
          report_mismatch("offset_present", 32'(offset_present_o),
                          32'(want.offset_present));
        end
        if (seg_offset_o !== want.seg_offset) begin
          report_mismatch("seg_offset", 32'(seg_offset_o), 32'(want.seg_offset));
        end
        if (seg_bytes_o !== want.seg_bytes) begin
          report_mismatch("seg_bytes", 32'(seg_bytes_o), 32'(want.seg_bytes));
        end
        if (more_data_o !== want.more_data) begin
          report_mismatch("more_data", 32'(more_data_o), 32'(want.more_data));
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("no request or result moved for %0d cycles", IdleLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Requests before any SDU, and an empty SDU: all grants and marks fail.
  task automatic test_empty_unit();
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd100, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd5, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'd0, 16'hFFFF, 8'hFF);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'hFFFF, 16'd1, 8'hFF);
  endtask

  // Largest SDU, zero and largest grants, exhausted SDU and resent segments.
  task automatic test_field_extremes();
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'hFFFF, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd1, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'hFFFF, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd7, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd1, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd1, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd1);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd100, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'hFFFF, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'hFF);
  endtask

  // Every SI code on first transmission; first, middle and last on resegmentation.
  task automatic test_si_codes();
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'd10, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd3, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd3, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd10, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd1);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd2, 8'd0);
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'd100, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdGrant, 16'd0, 16'd100, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd40, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd40, 8'd0);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd40, 8'd0);
  endtask

  // Fills all sequence numbers, then one more grant; a new SDU clears the table.
  task automatic test_table_full();
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'd300, 16'd0, 8'd0);
    repeat (MaxSegs + 1) begin
      send_request(rlc_am_seg_pkg::CmdGrant, 16'($urandom_range(0, 65535)), 16'd1, 8'd0);
    end
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'hFF);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd9, 8'd0);
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'd5, 16'd0, 8'd0);
    send_request(rlc_am_seg_pkg::CmdMark, 16'd0, 16'd0, 8'd200);
    send_request(rlc_am_seg_pkg::CmdRetx, 16'd0, 16'd9, 8'd0);
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_hold_left = 200;
    repeat (12) send_random_request();
    tx_gaps_on   = 1'b1;
  endtask

  // A stretch with no idling on either side.
  task automatic test_steady_flow();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (80) send_random_request();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Random SDUs cut into random segments, with marks and resegmentation.
  task automatic test_random_traffic();
    send_request(rlc_am_seg_pkg::CmdNewSdu, 16'($urandom_range(1, 600)),
                 16'($urandom_range(0, 65535)), 8'd0);
    repeat (RandomOps) send_random_request();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = rlc_am_seg_pkg::CmdNewSdu;
    sdu_length_i = '0;
    grant_size_i = '0;
    target_sn_i  = '0;
    mismatches   = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    rx_hold_left = 0;
    rx_gap_left  = 0;
    idle_cycles  = 0;
    sdu_bytes    = 0;
    sent_bytes   = 0;
    sn_counter   = 0;
    resend_sn    = '0;
    resend_done  = 0;
    resend_armed = 1'b0;
    foreach (rec_valid[i]) rec_valid[i] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_unit();
    test_field_extremes();
    test_si_codes();
    test_table_full();
    test_backpressure();
    test_steady_flow();
    test_random_traffic();

    // Drain: every predicted descriptor must arrive, then allow a little tail.
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
